// ===== hw/rtl/lyric_timestamp_parser_defines.svh =====
// ---------------------------------------------------------------------------
// Lyric timestamp parser assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LYRIC_TIMESTAMP_PARSER_DEFINES_SVH
`define LYRIC_TIMESTAMP_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define LTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define LTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define LTS_ASSERT_SAME(label, ante, cons)

`define LTS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/lts_pkg.sv =====
// ---------------------------------------------------------------------------
// Lyric timestamp parser package
// Widths, constants, character classes and the record passed front to back.
// ---------------------------------------------------------------------------
package lts_pkg;

    localparam int COMPONENT_BITS = 20;
    localparam int DUR_W          = 37;

    localparam logic [15:0] MS_PER_MIN   = 16'd60000;
    localparam logic [15:0] MS_PER_SEC   = 16'd1000;
    localparam logic [15:0] MS_PER_CENTI = 16'd10;
    localparam logic [7:0]  SEC_LIMIT    = 8'd60;
    localparam logic [7:0]  CENTI_LIMIT  = 8'd100;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [1:0] CNT_SAT = 2'd2;

    typedef logic [COMPONENT_BITS-1:0] comp_t;

    typedef enum logic [1:0] {
        RUN_MIN = 2'd0,
        RUN_SEC = 2'd1,
        RUN_CEN = 2'd2
    } run_t;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_COLON,
        CLS_DOT,
        CLS_SIGN,
        CLS_ILLEGAL
    } char_class_t;

    typedef struct packed {
        logic  ok;
        logic  neg;
        comp_t min;
        comp_t sec;
        comp_t cen;
    } rec_t;

    function automatic char_class_t classify(input logic [7:0] ch, input logic first);
        char_class_t cls;
        unique case (ch) inside
            [CHAR_ZERO:CHAR_NINE]: cls = CLS_DIGIT;
            CHAR_COLON:            cls = CLS_COLON;
            CHAR_DOT:              cls = CLS_DOT;
            CHAR_MINUS:            cls = first ? CLS_SIGN : CLS_ILLEGAL;
            default:               cls = CLS_ILLEGAL;
        endcase
        return cls;
    endfunction

    function automatic comp_t sat_digit(input comp_t acc, input logic [3:0] d);
        logic [COMPONENT_BITS+3:0] ext;
        logic [COMPONENT_BITS+3:0] nxt;
        ext = {4'b0000, acc};
        nxt = (ext << 3) + (ext << 1) + {{COMPONENT_BITS{1'b0}}, d};
        return (nxt[COMPONENT_BITS+3:COMPONENT_BITS] != 4'd0) ? {COMPONENT_BITS{1'b1}}
                                                               : nxt[COMPONENT_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/lts_front.sv =====
// ---------------------------------------------------------------------------
// Lyric timestamp parser front end
// Classifies each character, accumulates the digit runs and, on the last
// character, pushes one record for the arithmetic back end.
// ---------------------------------------------------------------------------
module lts_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    character,
    input  logic          last,
    input  logic          push,
    input  logic          queue_full,
    output logic          rec_push,
    output lts_pkg::rec_t rec
);

    logic                first_reg,   first_next;
    logic                neg_reg,     neg_next;
    logic [1:0]          colon_reg,   colon_next;
    logic [1:0]          dot_reg,     dot_next;
    logic                illegal_reg, illegal_next;
    lts_pkg::run_t       run_reg,     run_next;
    lts_pkg::comp_t      min_reg,     min_next;
    lts_pkg::comp_t      sec_reg,     sec_next;
    lts_pkg::comp_t      cen_reg,     cen_next;
    logic [2:0]          has_reg,     has_next;
    logic                accept;
    lts_pkg::char_class_t cls;
    logic [3:0]          digit;

    assign accept = push && !queue_full;
    assign cls    = lts_pkg::classify(character, first_reg);
    assign digit  = 4'(character - lts_pkg::CHAR_ZERO);

    always_comb
    begin
        first_next   = 1'b0;
        neg_next     = neg_reg;
        colon_next   = colon_reg;
        dot_next     = dot_reg;
        illegal_next = illegal_reg;
        run_next     = run_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        cen_next     = cen_reg;
        has_next     = has_reg;
        unique case (cls)
            lts_pkg::CLS_DIGIT:
            begin
                unique case (run_reg)
                    lts_pkg::RUN_MIN:
                    begin
                        min_next    = lts_pkg::sat_digit(min_reg, digit);
                        has_next[0] = 1'b1;
                    end
                    lts_pkg::RUN_SEC:
                    begin
                        sec_next    = lts_pkg::sat_digit(sec_reg, digit);
                        has_next[1] = 1'b1;
                    end
                    default:
                    begin
                        cen_next    = lts_pkg::sat_digit(cen_reg, digit);
                        has_next[2] = 1'b1;
                    end
                endcase
            end
            lts_pkg::CLS_COLON:
            begin
                colon_next = (colon_reg == lts_pkg::CNT_SAT) ? colon_reg : colon_reg + 2'd1;
                run_next   = lts_pkg::RUN_SEC;
            end
            lts_pkg::CLS_DOT:
            begin
                dot_next = (dot_reg == lts_pkg::CNT_SAT) ? dot_reg : dot_reg + 2'd1;
                run_next = lts_pkg::RUN_CEN;
            end
            lts_pkg::CLS_SIGN:
            begin
                neg_next = 1'b1;
            end
            default:
            begin
                illegal_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        rec_push = accept && last;
        rec.ok   = (colon_next == 2'd1) && (dot_next == 2'd1) && !illegal_next
                   && (has_next == 3'b111);
        rec.neg  = neg_next;
        rec.min  = min_next;
        rec.sec  = sec_next;
        rec.cen  = cen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg   <= 1'b1;
            neg_reg     <= 1'b0;
            colon_reg   <= 2'd0;
            dot_reg     <= 2'd0;
            illegal_reg <= 1'b0;
            run_reg     <= lts_pkg::RUN_MIN;
            min_reg     <= '0;
            sec_reg     <= '0;
            cen_reg     <= '0;
            has_reg     <= 3'b000;
        end
        else if (accept)
        begin
            if (last)
            begin
                first_reg   <= 1'b1;
                neg_reg     <= 1'b0;
                colon_reg   <= 2'd0;
                dot_reg     <= 2'd0;
                illegal_reg <= 1'b0;
                run_reg     <= lts_pkg::RUN_MIN;
                min_reg     <= '0;
                sec_reg     <= '0;
                cen_reg     <= '0;
                has_reg     <= 3'b000;
            end
            else
            begin
                first_reg   <= first_next;
                neg_reg     <= neg_next;
                colon_reg   <= colon_next;
                dot_reg     <= dot_next;
                illegal_reg <= illegal_next;
                run_reg     <= run_next;
                min_reg     <= min_next;
                sec_reg     <= sec_next;
                cen_reg     <= cen_next;
                has_reg     <= has_next;
            end
        end
    end

endmodule

// ===== hw/rtl/lts_queue.sv =====
// ---------------------------------------------------------------------------
// Lyric timestamp parser record queue
// Two-entry queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module lts_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  lts_pkg::rec_t wr_rec,
    output logic          q_full,
    input  logic          rd_en,
    output lts_pkg::rec_t rd_rec,
    output logic          q_empty
);

    lts_pkg::rec_t mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg,  count_next;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_rec  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/lts_back.sv =====
// ---------------------------------------------------------------------------
// Lyric timestamp parser back end
// Scales the three parts to milliseconds, sums them, applies the sign and
// holds the result in an output register.
// ---------------------------------------------------------------------------
module lts_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  lts_pkg::rec_t                   rd_rec,
    output logic                            rd_en,
    output logic                            valid_res,
    output logic signed [lts_pkg::DUR_W-1:0] duration_ms,
    output logic                            out_of_range_parts,
    output logic                            empty,
    input  logic                            pop
);

    localparam int DW = lts_pkg::DUR_W;
    localparam int CB = lts_pkg::COMPONENT_BITS;

    logic          s1_valid_reg;
    logic          s1_ok_reg;
    logic          s1_neg_reg;
    logic          s1_flag_reg;
    logic [DW-1:0] s1_pmin_reg, s1_pmin_next;
    logic [DW-1:0] s1_psec_reg, s1_psec_next;
    logic [DW-1:0] s1_pcen_reg, s1_pcen_next;
    logic          s1_flag_next;
    logic          s1_adv;
    logic          out_valid_reg;
    logic          ok_reg;
    logic [DW-1:0] dur_reg,     dur_next;
    logic          oor_reg;
    logic [DW-1:0] sum;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || pop);
    assign rd_en  = !q_empty && (!s1_valid_reg || s1_adv);

    always_comb
    begin
        s1_pmin_next = '0;
        s1_psec_next = '0;
        s1_pcen_next = '0;
        s1_flag_next = 1'b0;
        if (rd_rec.ok)
        begin
            s1_pmin_next = DW'(rd_rec.min) * DW'(lts_pkg::MS_PER_MIN);
            s1_psec_next = DW'(rd_rec.sec) * DW'(lts_pkg::MS_PER_SEC);
            s1_pcen_next = DW'(rd_rec.cen) * DW'(lts_pkg::MS_PER_CENTI);
            s1_flag_next = (rd_rec.sec >= CB'(lts_pkg::SEC_LIMIT))
                           || (rd_rec.cen >= CB'(lts_pkg::CENTI_LIMIT));
        end
    end

    always_comb
    begin
        sum      = s1_pmin_reg + s1_psec_reg + s1_pcen_reg;
        dur_next = s1_neg_reg ? (~sum + DW'(1)) : sum;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_ok_reg   <= rd_rec.ok;
            s1_neg_reg  <= rd_rec.neg;
            s1_flag_reg <= s1_flag_next;
            s1_pmin_reg <= s1_pmin_next;
            s1_psec_reg <= s1_psec_next;
            s1_pcen_reg <= s1_pcen_next;
        end
        if (s1_adv)
        begin
            ok_reg  <= s1_ok_reg;
            dur_reg <= dur_next;
            oor_reg <= s1_flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty              = !out_valid_reg;
    assign valid_res          = ok_reg;
    assign duration_ms        = signed'(dur_reg);
    assign out_of_range_parts = oor_reg;

endmodule

// ===== hw/rtl/lyric_timestamp_parser.sv =====
// ---------------------------------------------------------------------------
// Lyric timestamp parser
// Parses [-]mm:ss.cc text, one character per beat, into signed milliseconds.
//
// Channel   Direction  Handshake      Payload
// input     in         push / full    character, last
// result    out        pop / empty    valid_res, duration_ms, out_of_range_parts
//
// One character is taken every cycle while full is low; the character accumulators
// are registered and update at the edge that takes each character. A result
// passes from the queue through the scaling stage to the output register. The
// back end scales the parts in one stage and sums and signs in the next.
// Reset clears the parse state and empties the queue and output register.
// Full rises only when two records wait in the queue behind a loaded scaling
// stage and a stalled result.
// ---------------------------------------------------------------------------
`include "lyric_timestamp_parser_defines.svh"

module lyric_timestamp_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [7:0]                       character,
    input  logic                             last,
    input  logic                             push,
    output logic                             full,
    output logic                             valid_res,
    output logic signed [lts_pkg::DUR_W-1:0] duration_ms,
    output logic                             out_of_range_parts,
    output logic                             empty,
    input  logic                             pop
);

    logic          rec_push;
    lts_pkg::rec_t wr_rec;
    lts_pkg::rec_t rd_rec;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    assign full = q_full;

    lts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .character  (character),
        .last       (last),
        .push       (push),
        .queue_full (q_full),
        .rec_push   (rec_push),
        .rec        (wr_rec)
    );

    lts_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_rec  (wr_rec),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_rec  (rd_rec),
        .q_empty (q_empty)
    );

    lts_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_empty            (q_empty),
        .rd_rec             (rd_rec),
        .rd_en              (q_pop),
        .valid_res          (valid_res),
        .duration_ms        (duration_ms),
        .out_of_range_parts (out_of_range_parts),
        .empty              (empty),
        .pop                (pop)
    );

    `LTS_ASSERT_SAME(a_push_not_full, rec_push, !q_full)
    `LTS_ASSERT_NEXT(a_record_kept, rec_push && !q_pop, !q_empty)
    `LTS_ASSERT_SAME(a_invalid_zero, !empty && !valid_res, (duration_ms == '0) && !out_of_range_parts)

endmodule
